// ----- src/rdde_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdde_pkg
// Shared types and codes for the reversible deque drop engine.
// ----------------------------------------------------------------------------
package rdde_pkg;

	localparam int ValueW = 32;

	typedef logic signed [ValueW-1:0] value_t;

	typedef enum logic [1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_REVERSE = 2'd1,
		FUNC_DROP    = 2'd2,
		FUNC_FINISH  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_ELEMENT   = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		func_t  func;
		value_t value;
	} cmd_t;

	typedef enum logic {
		BK_IDLE   = 1'b0,
		BK_STREAM = 1'b1
	} back_state_t;

endpackage

// ----- src/rdde_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdde_item_if
// Request channel into the deque engine: func and value with valid/ready.
// ----------------------------------------------------------------------------
interface rdde_item_if;
	logic             valid;
	logic             ready;
	rdde_pkg::func_t  func;
	rdde_pkg::value_t value;

	modport source(output valid, output func, output value, input ready);
	modport sink(input valid, input func, input value, output ready);
endinterface

// ----- src/rdde_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdde_result_if
// Result channel out of the deque engine: status, value and last marker.
// ----------------------------------------------------------------------------
interface rdde_result_if;
	logic              valid;
	logic              ready;
	rdde_pkg::status_t status;
	rdde_pkg::value_t  value_res;
	logic              last;

	modport source(output valid, output status, output value_res, output last, input ready);
	modport sink(input valid, input status, input value_res, input last, output ready);
endinterface

// ----- src/rdde_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdde_front
// Input stage: takes requests, decodes them into commands and registers them.
// ----------------------------------------------------------------------------
module rdde_front (
	input  logic           clk,
	input  logic           arst_n,
	rdde_item_if.sink      item,
	output logic           cmd_valid,
	output rdde_pkg::cmd_t cmd,
	input  logic           cmd_ready
);

	logic           valid_s1;
	rdde_pkg::cmd_t cmd_s1;

	assign item.ready = !valid_s1 || cmd_ready;
	assign cmd_valid  = valid_s1;
	assign cmd        = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// value only matters for loads; zero it otherwise
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1.func  <= item.func;
			cmd_s1.value <= (item.func == rdde_pkg::FUNC_LOAD) ? item.value : '0;
		end
	end

endmodule

// ----- src/rdde_cmd_q.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdde_cmd_q
// Two-entry command queue between the front stage and the deque engine.
// ----------------------------------------------------------------------------
module rdde_cmd_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  rdde_pkg::cmd_t push_cmd,
	output logic           push_ready,
	output logic           pop_valid,
	output rdde_pkg::cmd_t pop_cmd,
	input  logic           pop_ready
);

	localparam int Depth = 2;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	rdde_pkg::cmd_t      entry_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     cnt_q;
	logic                push_fire;
	logic                pop_fire;

	assign push_ready = (cnt_q != CntW'(Depth));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- src/rdde_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdde_back
// Deque engine: ring-buffer store, direction and error flags, finish streaming
// through a registered read into the result register.
// ----------------------------------------------------------------------------
module rdde_back #(
	parameter int DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  rdde_pkg::cmd_t cmd,
	output logic           cmd_ready,
	rdde_result_if.source  result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DepthW = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] DepthC = CW'(DEPTH);

	rdde_pkg::value_t      mem [DEPTH];
	rdde_pkg::value_t      rd_data_q;

	rdde_pkg::back_state_t state_q, state_d;
	logic [AW-1:0]         head_q, head_d;
	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         idx_q, idx_d;
	logic                  rev_q, rev_d;
	logic                  udf_q, udf_d;
	logic                  ovf_q, ovf_d;

	logic                  out_valid_q, out_valid_d;
	rdde_pkg::status_t     out_status_q, out_status_d;
	logic                  out_last_q, out_last_d;
	logic                  out_elem_q, out_elem_d;

	logic                  slot_free;
	logic                  wr_en;
	logic                  rd_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [CW-1:0]         rd_off;
	logic                  stream_last;

	// sum is below twice DEPTH, so one compare and subtract wraps it
	function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
		logic [AW:0] r;
		r = (s >= DepthW) ? s - DepthW : s;
		return r[AW-1:0];
	endfunction

	assign slot_free   = !out_valid_q || result.ready;
	assign wr_addr     = wrap_idx({1'b0, head_q} + (AW + 1)'(count_q));
	assign rd_off      = rev_q ? (count_q - 1'b1 - idx_q) : idx_q;
	assign rd_addr     = wrap_idx({1'b0, head_q} + (AW + 1)'(rd_off));
	assign stream_last = ((idx_q + 1'b1) == count_q);

	assign result.valid     = out_valid_q;
	assign result.status    = out_status_q;
	assign result.value_res = out_elem_q ? rd_data_q : '0;
	assign result.last      = out_last_q;

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		count_d      = count_q;
		idx_d        = idx_q;
		rev_d        = rev_q;
		udf_d        = udf_q;
		ovf_d        = ovf_q;
		out_valid_d  = out_valid_q && !result.ready;
		out_status_d = out_status_q;
		out_last_d   = out_last_q;
		out_elem_d   = out_elem_q;
		cmd_ready    = 1'b0;
		wr_en        = 1'b0;
		rd_en        = 1'b0;

		case (state_q)
			rdde_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.func)
						rdde_pkg::FUNC_LOAD: begin
							cmd_ready = 1'b1;
							if (count_q >= DepthC) begin
								ovf_d = 1'b1;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						rdde_pkg::FUNC_REVERSE: begin
							cmd_ready = 1'b1;
							rev_d     = !rev_q;
						end
						rdde_pkg::FUNC_DROP: begin
							cmd_ready = 1'b1;
							if (count_q == '0) begin
								udf_d = 1'b1;
							end else begin
								// reversed: logical front is the physical back
								if (!rev_q) begin
									head_d = wrap_idx({1'b0, head_q} + (AW + 1)'(1));
								end
								count_d = count_q - 1'b1;
							end
						end
						rdde_pkg::FUNC_FINISH: begin
							if (slot_free) begin
								cmd_ready = 1'b1;
								if (udf_q || ovf_q || count_q == '0) begin
									out_valid_d  = 1'b1;
									out_last_d   = 1'b1;
									out_elem_d   = 1'b0;
									if (udf_q) begin
										out_status_d = rdde_pkg::ST_UNDERFLOW;
									end else if (ovf_q) begin
										out_status_d = rdde_pkg::ST_OVERFLOW;
									end else begin
										out_status_d = rdde_pkg::ST_EMPTY;
									end
									head_d  = '0;
									count_d = '0;
									rev_d   = 1'b0;
									udf_d   = 1'b0;
									ovf_d   = 1'b0;
								end else begin
									idx_d   = '0;
									state_d = rdde_pkg::BK_STREAM;
								end
							end
						end
						default: begin
							cmd_ready = 1'b0;
						end
					endcase
				end
			end
			rdde_pkg::BK_STREAM: begin
				if (slot_free) begin
					rd_en        = 1'b1;
					out_valid_d  = 1'b1;
					out_status_d = rdde_pkg::ST_ELEMENT;
					out_last_d   = stream_last;
					out_elem_d   = 1'b1;
					idx_d        = idx_q + 1'b1;
					if (stream_last) begin
						head_d  = '0;
						count_d = '0;
						rev_d   = 1'b0;
						udf_d   = 1'b0;
						ovf_d   = 1'b0;
						state_d = rdde_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = rdde_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdde_pkg::BK_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			rev_q       <= 1'b0;
			udf_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			rev_q       <= rev_d;
			udf_q       <= udf_d;
			ovf_q       <= ovf_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_status_q <= out_status_d;
		out_last_q   <= out_last_d;
		out_elem_q   <= out_elem_d;
	end

	// element store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// ----- src/reversible_deque_drop_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_deque_drop_engine_unit
// Bounded ring-buffer deque with direction flag, front drop and streamed finish.
// ----------------------------------------------------------------------------
// Load, reverse and drop requests produce no result. A finish request
// produces one result when the list is empty or an error flag is set,
// otherwise it streams the remaining elements in logical order at one per
// cycle while the result slot is free, limited by the single read port of the
// element store; the engine takes the finish request and then sends one
// result per element. Requests pass a front register and a two-entry command
// queue, so up to three new requests are taken while the engine streams; while
// a result waits, only a finish is held back. Loads past DEPTH are discarded
// and reported at finish as overflow; a drop on an empty list is reported at
// finish as an error and takes priority over overflow. Each finish clears the
// list, the direction and both flags.
// ----------------------------------------------------------------------------
module reversible_deque_drop_engine_unit #(
	parameter int DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	rdde_item_if.sink     item,
	rdde_result_if.source result
);

	logic           push_valid;
	rdde_pkg::cmd_t push_cmd;
	logic           push_ready;
	logic           pop_valid;
	rdde_pkg::cmd_t pop_cmd;
	logic           pop_ready;

	rdde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (push_valid),
		.cmd       (push_cmd),
		.cmd_ready (push_ready)
	);

	rdde_cmd_q u_cmd_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop_ready  (pop_ready)
	);

	rdde_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.cmd_ready (pop_ready),
		.result    (result)
	);

endmodule
